[src/assert_macros.svh]
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(name, expr) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("assertion failed");
`define ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(name, expr)
`define ASSERT_NEXT(name, ante, cons)
`endif
`endif

[src/rqee_pkg.sv]
// shared constants and the error probability table function
`default_nettype none
package rqee_pkg;

  localparam int unsigned CharW     = 8;
  localparam int unsigned OutW      = 48;
  localparam int unsigned RomDepth  = 256;
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned WorkBits  = 62;

  localparam logic [1:0] RegAsciiOffset = 2'd0;
  localparam logic [1:0] RegQualMin     = 2'd1;
  localparam logic [1:0] RegQualMax     = 2'd2;

  localparam logic [CharW-1:0] AsciiOffsetReset = 8'd33;
  localparam logic [CharW-1:0] QualMinReset     = 8'd0;
  localparam logic [CharW-1:0] QualMaxReset     = 8'd41;
  localparam logic [CharW-1:0] LowSeenReset     = 8'd255;

  localparam logic [63:0] DecOne = 64'd1000000000000000000;

  // 10^(-k/10) scaled by 10^18
  localparam logic [63:0] TenthPow [10] = '{
    64'd1000000000000000000,
    64'd794328234724281502,
    64'd630957344480193250,
    64'd501187233627272285,
    64'd398107170553497251,
    64'd316227766016837933,
    64'd251188643150957883,
    64'd199526231496887960,
    64'd158489319246111349,
    64'd125892541179416721
  };

  // 10^(-q/10) rounded half up to frac fraction bits, evaluated at elaboration
  function automatic logic [63:0] prob_of_qual(input int unsigned q, input int unsigned frac);
    int unsigned k;
    int unsigned d;
    logic [63:0] r;
    logic [63:0] x;
    k = q;
    d = 0;
    for (int i = 0; i < 26; i++) begin
      if (k >= 10) begin
        k = k - 10;
        d = d + 1;
      end
    end
    if (k == 0) begin
      x = 64'd1 << WorkBits;
      r = 64'd0;
    end else begin
      x = 64'd0;
      r = TenthPow[k];
    end
    for (int b = WorkBits - 1; b >= 0; b--) begin
      r = r << 1;
      if (r >= DecOne) begin
        r = r - DecOne;
        x = x | (64'd1 << b);
      end
    end
    for (int unsigned i = 0; i < d; i++) begin
      x = x / 64'd10;
    end
    x = x + (64'd1 << (WorkBits - frac - 1));
    return x >> (WorkBits - frac);
  endfunction

endpackage
`default_nettype wire

[src/read_quality_expected_errors.sv]
// expected errors of a read from its quality characters, top level
// result path: front register, then the queue, then the result register
// throughput: one character per cycle unless the queue or result slot is full
// the result register lets the next read stream in while a result waits for pop
// reset: offset 33, quality window 0 to 41, sum and max cleared, min set to 255
// no clearing pass: the block takes characters from the first cycle after reset
`default_nettype none
`include "assert_macros.svh"
module read_quality_expected_errors #(
  parameter int unsigned PROB_FRAC_BITS = 32,
  parameter int unsigned SUM_INT_BITS   = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [rqee_pkg::CharW-1:0]   qual_char_i,
  input  wire logic                         last_i,
  output logic                              empty,
  input  wire logic                         pop,
  output logic      [rqee_pkg::OutW-1:0]    expected_errors_o,
  output logic      [rqee_pkg::CharW-1:0]   min_char_o,
  output logic      [rqee_pkg::CharW-1:0]   max_char_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [1:0]                   cfg_idx_i,
  input  wire logic [rqee_pkg::CharW-1:0]   cfg_wdata_i
);

  localparam int unsigned CharW = rqee_pkg::CharW;
  localparam int unsigned ProbW = PROB_FRAC_BITS + 1;
  localparam int unsigned FullW = SUM_INT_BITS + PROB_FRAC_BITS;
  localparam int unsigned SumW  = (FullW > rqee_pkg::OutW) ? rqee_pkg::OutW : FullW;
  localparam int unsigned ItemW = ProbW + CharW + 1;

  logic [CharW-1:0] ascii_offset_q, qual_min_q, qual_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ascii_offset_q <= rqee_pkg::AsciiOffsetReset;
      qual_min_q     <= rqee_pkg::QualMinReset;
      qual_max_q     <= rqee_pkg::QualMaxReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rqee_pkg::RegAsciiOffset: ascii_offset_q <= cfg_wdata_i;
        rqee_pkg::RegQualMin:     qual_min_q     <= cfg_wdata_i;
        rqee_pkg::RegQualMax:     qual_max_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic             fr_valid, fr_ready, fr_last, fifo_full;
  logic [ProbW-1:0] fr_prob;
  logic [CharW-1:0] fr_char;
  logic             bk_valid, bk_ready;
  logic [ItemW-1:0] bk_item;

  rqee_front #(
    .ProbFracBits(PROB_FRAC_BITS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .push_i         (push),
    .full_o         (full),
    .qual_char_i,
    .last_i,
    .ascii_offset_i (ascii_offset_q),
    .qual_min_i     (qual_min_q),
    .qual_max_i     (qual_max_q),
    .out_valid_o    (fr_valid),
    .out_ready_i    (fr_ready),
    .prob_o         (fr_prob),
    .char_o         (fr_char),
    .last_o         (fr_last)
  );

  rqee_fifo #(
    .Width(ItemW)
  ) u_fifo (
    .clk_i,
    .rst_ni,
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .wr_data_i  ({fr_prob, fr_char, fr_last}),
    .rd_valid_o (bk_valid),
    .rd_ready_i (bk_ready),
    .rd_data_o  (bk_item),
    .full_o     (fifo_full)
  );

  rqee_back #(
    .ProbW(ProbW),
    .SumW (SumW)
  ) u_back (
    .clk_i,
    .rst_ni,
    .in_valid_i        (bk_valid),
    .in_ready_o        (bk_ready),
    .prob_i            (bk_item[ItemW-1:CharW+1]),
    .char_i            (bk_item[CharW:1]),
    .last_i            (bk_item[0]),
    .empty_o           (empty),
    .pop_i             (pop),
    .expected_errors_o,
    .min_char_o,
    .max_char_o
  );

  // input stalls only when the queue behind the front stage is full
  `ASSERT_ALWAYS(a_full_needs_queue_full, !full || fifo_full)
  // a finished read has seen at least one character
  `ASSERT_ALWAYS(a_min_not_above_max, empty || (min_char_o <= max_char_o))
  // a waiting result holds its sum until it is popped
  `ASSERT_NEXT(a_result_stable, !empty && !pop, $stable(expected_errors_o))

endmodule
`default_nettype wire

[src/rqee_fifo.sv]
// short queue between the classify front and the accumulate back
`default_nettype none
module rqee_fifo #(
  parameter int unsigned Width = 43
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_valid_i,
  output logic                  wr_ready_o,
  input  wire logic [Width-1:0] wr_data_i,
  output logic                  rd_valid_o,
  input  wire logic             rd_ready_i,
  output logic      [Width-1:0] rd_data_o,
  output logic                  full_o
);

  localparam int unsigned Depth = rqee_pkg::FifoDepth;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             wr_fire, rd_fire;

  assign full_o     = (count_q == CntW'(Depth));
  assign wr_ready_o = !full_o;
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign wr_fire    = wr_valid_i && wr_ready_o;
  assign rd_fire    = rd_valid_o && rd_ready_i;

  always_comb begin
    wr_ptr_d = wr_fire ? PtrW'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = rd_fire ? PtrW'(rd_ptr_q + 1'b1) : rd_ptr_q;
    count_d  = count_q;
    if (wr_fire && !rd_fire) begin
      count_d = CntW'(count_q + 1'b1);
    end else if (rd_fire && !wr_fire) begin
      count_d = CntW'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_fire) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule
`default_nettype wire

[src/rqee_front.sv]
// input stage: quality window check and probability table lookup
`default_nettype none
module rqee_front #(
  parameter int unsigned ProbFracBits = 32,
  localparam int unsigned ProbW = ProbFracBits + 1
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push_i,
  output logic                              full_o,
  input  wire logic [rqee_pkg::CharW-1:0]   qual_char_i,
  input  wire logic                         last_i,
  input  wire logic [rqee_pkg::CharW-1:0]   ascii_offset_i,
  input  wire logic [rqee_pkg::CharW-1:0]   qual_min_i,
  input  wire logic [rqee_pkg::CharW-1:0]   qual_max_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [ProbW-1:0]             prob_o,
  output logic      [rqee_pkg::CharW-1:0]   char_o,
  output logic                              last_o
);

  localparam int unsigned CharW = rqee_pkg::CharW;

  logic [ProbW-1:0] rom [rqee_pkg::RomDepth];

  for (genvar g = 0; g < rqee_pkg::RomDepth; g++) begin : g_rom
    localparam logic [63:0] Val = rqee_pkg::prob_of_qual(g, ProbFracBits);
    assign rom[g] = Val[ProbW-1:0];
  end

  logic             valid_q, valid_d;
  logic [CharW-1:0] char_q, qual_q, qual_d;
  logic             last_q, in_win_q, in_win_d;
  logic             in_fire;

  assign full_o  = valid_q && !out_ready_i;
  assign in_fire = push_i && !full_o;

  always_comb begin
    qual_d   = qual_char_i - ascii_offset_i;
    in_win_d = (qual_char_i >= ascii_offset_i) && (qual_d >= qual_min_i)
               && (qual_d <= qual_max_i);
    valid_d  = valid_q;
    if (in_fire) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      char_q   <= qual_char_i;
      last_q   <= last_i;
      qual_q   <= qual_d;
      in_win_q <= in_win_d;
    end
  end

  assign out_valid_o = valid_q;
  assign prob_o      = in_win_q ? rom[qual_q] : '0;
  assign char_o      = char_q;
  assign last_o      = last_q;

endmodule
`default_nettype wire

[src/rqee_back.sv]
// accumulate stage: saturating sum, min and max, result register
`default_nettype none
module rqee_back #(
  parameter int unsigned ProbW = 33,
  parameter int unsigned SumW  = 48
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [ProbW-1:0]             prob_i,
  input  wire logic [rqee_pkg::CharW-1:0]   char_i,
  input  wire logic                         last_i,
  output logic                              empty_o,
  input  wire logic                         pop_i,
  output logic      [rqee_pkg::OutW-1:0]    expected_errors_o,
  output logic      [rqee_pkg::CharW-1:0]   min_char_o,
  output logic      [rqee_pkg::CharW-1:0]   max_char_o
);

  localparam int unsigned CharW = rqee_pkg::CharW;

  logic [SumW-1:0]  sum_q, sum_d, sum_new;
  logic [SumW:0]    sum_wide;
  logic [CharW-1:0] lo_q, lo_d, lo_new;
  logic [CharW-1:0] hi_q, hi_d, hi_new;
  logic             res_valid_q, res_valid_d;
  logic [SumW-1:0]  res_sum_q;
  logic [CharW-1:0] res_lo_q, res_hi_q;
  logic             slot_free, in_fire;

  assign slot_free  = !res_valid_q || pop_i;
  assign in_ready_o = !last_i || slot_free;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    sum_wide = {1'b0, sum_q} + (SumW + 1)'(prob_i);
    sum_new  = sum_wide[SumW] ? '1 : sum_wide[SumW-1:0];
    lo_new   = (char_i < lo_q) ? char_i : lo_q;
    hi_new   = (char_i > hi_q) ? char_i : hi_q;
    sum_d    = sum_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    if (in_fire) begin
      if (last_i) begin
        sum_d = '0;
        lo_d  = rqee_pkg::LowSeenReset;
        hi_d  = '0;
      end else begin
        sum_d = sum_new;
        lo_d  = lo_new;
        hi_d  = hi_new;
      end
    end
    res_valid_d = res_valid_q;
    if (in_fire && last_i) begin
      res_valid_d = 1'b1;
    end else if (pop_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      lo_q        <= rqee_pkg::LowSeenReset;
      hi_q        <= '0;
      res_valid_q <= 1'b0;
    end else begin
      sum_q       <= sum_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && last_i) begin
      res_sum_q <= sum_new;
      res_lo_q  <= lo_new;
      res_hi_q  <= hi_new;
    end
  end

  assign empty_o           = !res_valid_q;
  assign expected_errors_o = rqee_pkg::OutW'(res_sum_q);
  assign min_char_o        = res_lo_q;
  assign max_char_o        = res_hi_q;

endmodule
`default_nettype wire
